[src/dehg_pkg.sv]
// shared types and constants for the directory entry header grouper
// no dependencies
package dehg_pkg;

    localparam int unsigned METADATA_BYTES_DEF = 8192;
    localparam int unsigned ENTRY_BYTES        = 8;
    localparam int unsigned HEADER_BYTES       = 12;
    localparam int unsigned GROUP_SPAN_MAX     = 255;
    localparam int unsigned INDEX_SPACING      = 128;
    localparam int unsigned INDEX_COUNT_MAX    = 65535;

    typedef struct packed {
        logic [31:0] inode_block;
        logic [31:0] inode_num;
        logic [8:0]  name_len;
        logic        last_entry;
    } entry_t;

    typedef struct packed {
        logic               new_header;
        logic signed [15:0] inode_delta;
        logic [7:0]         name_size;
        logic               prev_group_closed;
        logic [7:0]         prev_group_count;
        logic [7:0]         final_group_count;
        logic [31:0]        end_offset;
        logic               index_entry;
        logic [15:0]        index_count;
        logic               done_res;
    } result_t;

endpackage

[src/dehg_core.sv]
// group state and per-entry decision logic of the header grouper
// depends on dehg_pkg
module dehg_core #(
    parameter int unsigned METADATA_BYTES = dehg_pkg::METADATA_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  dehg_pkg::entry_t entry,
    output dehg_pkg::result_t result
);

    logic        have_group_reg,         have_group_next;
    logic [31:0] group_block_reg,        group_block_next;
    logic [31:0] group_inode_reg,        group_inode_next;
    logic [31:0] group_start_offset_reg, group_start_offset_next;
    logic [31:0] group_serial_reg,       group_serial_next;
    logic [8:0]  group_entries_reg,      group_entries_next;
    logic [31:0] entry_serial_reg,       entry_serial_next;
    logic [31:0] running_offset_reg,     running_offset_next;
    logic [31:0] last_kept_serial_reg,   last_kept_serial_next;
    logic [15:0] kept_index_total_reg,   kept_index_total_next;

    logic [32:0] diff;
    logic        delta_out_of_range;
    logic [33:0] span;
    logic        span_over;
    logic [31:0] serial_dist;
    logic [31:0] kept_dist;
    logic        hdr;
    logic        closed;
    logic        kept;
    logic [8:0]  entries_upd;
    logic [31:0] offset_upd;
    logic [31:0] entry_size;
    logic [15:0] kept_total_upd;

    always_comb
    begin
        diff = {1'b0, entry.inode_num} - {1'b0, group_inode_reg};
        // delta fits 16 bits signed when bits 32..15 are all equal
        delta_out_of_range = !((&diff[32:15]) || !(|diff[32:15]));
        span = {2'b0, running_offset_reg - group_start_offset_reg}
             + 34'(dehg_pkg::ENTRY_BYTES) + {25'b0, entry.name_len};
        span_over   = span > 34'(METADATA_BYTES);
        serial_dist = entry_serial_reg - group_serial_reg;
        kept_dist   = entry_serial_reg - last_kept_serial_reg;

        hdr = !have_group_reg
           || (entry.inode_block != group_block_reg)
           || delta_out_of_range
           || span_over
           || (serial_dist > 32'(dehg_pkg::GROUP_SPAN_MAX));
        closed = hdr && have_group_reg;
        kept   = closed && (kept_dist > 32'(dehg_pkg::INDEX_SPACING));

        kept_total_upd = kept_index_total_reg;
        if (kept && kept_index_total_reg != 16'(dehg_pkg::INDEX_COUNT_MAX))
        begin
            kept_total_upd = kept_index_total_reg + 16'd1;
        end

        entry_size = 32'(dehg_pkg::ENTRY_BYTES) + {23'b0, entry.name_len}
                   + (hdr ? 32'(dehg_pkg::HEADER_BYTES) : 32'd0);
        offset_upd  = running_offset_reg + entry_size;
        entries_upd = (hdr ? 9'd0 : group_entries_reg) + 9'd1;

        result.new_header        = hdr;
        result.inode_delta       = hdr ? 16'sd0 : diff[15:0];
        result.name_size         = entry.name_len[7:0] - 8'd1;
        result.prev_group_closed = closed;
        result.prev_group_count  = closed ? group_entries_reg[7:0] - 8'd1 : 8'd0;
        result.final_group_count = entry.last_entry ? entries_upd[7:0] - 8'd1 : 8'd0;
        result.end_offset        = offset_upd;
        result.index_entry       = kept;
        result.index_count       = kept_total_upd;
        result.done_res          = entry.last_entry;

        have_group_next         = 1'b1;
        group_block_next        = hdr ? entry.inode_block : group_block_reg;
        group_inode_next        = hdr ? entry.inode_num : group_inode_reg;
        group_start_offset_next = hdr ? running_offset_reg : group_start_offset_reg;
        group_serial_next       = hdr ? entry_serial_reg : group_serial_reg;
        group_entries_next      = entries_upd;
        entry_serial_next       = entry_serial_reg + 32'd1;
        running_offset_next     = offset_upd;
        last_kept_serial_next   = (hdr && (!have_group_reg || kept))
                                ? entry_serial_reg : last_kept_serial_reg;
        kept_index_total_next   = kept_total_upd;

        // last entry of a directory returns everything to the reset state
        if (entry.last_entry)
        begin
            have_group_next         = 1'b0;
            group_block_next        = '0;
            group_inode_next        = '0;
            group_start_offset_next = '0;
            group_serial_next       = '0;
            group_entries_next      = '0;
            entry_serial_next       = '0;
            running_offset_next     = '0;
            last_kept_serial_next   = '0;
            kept_index_total_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_group_reg         <= 1'b0;
            group_block_reg        <= '0;
            group_inode_reg        <= '0;
            group_start_offset_reg <= '0;
            group_serial_reg       <= '0;
            group_entries_reg      <= '0;
            entry_serial_reg       <= '0;
            running_offset_reg     <= '0;
            last_kept_serial_reg   <= '0;
            kept_index_total_reg   <= '0;
        end
        else if (advance)
        begin
            have_group_reg         <= have_group_next;
            group_block_reg        <= group_block_next;
            group_inode_reg        <= group_inode_next;
            group_start_offset_reg <= group_start_offset_next;
            group_serial_reg       <= group_serial_next;
            group_entries_reg      <= group_entries_next;
            entry_serial_reg       <= entry_serial_next;
            running_offset_reg     <= running_offset_next;
            last_kept_serial_reg   <= last_kept_serial_next;
            kept_index_total_reg   <= kept_index_total_next;
        end
    end

endmodule

[src/dir_entry_header_grouper_unit.sv]
// top level of the directory entry header grouper: input and result registers
// depends on dehg_pkg and dehg_core
//
//   channel   beat type          handshake                  dir
//   entry     dehg_pkg::entry_t  entry_valid / entry_stall  in
//   result    dehg_pkg::result_t result_valid / result_stall out
//
// one entry per cycle sustained while result_stall is low; an entry beat passes the input
// register, then the group logic into the result register, to become a result beat
// the group state loop closes through the 32-bit offset add/compare
// reset clears the group state and both valid flags
// a stalled result holds the result register and entry_stall rises only when both stages are full
module dir_entry_header_grouper_unit #(
    parameter int unsigned METADATA_BYTES = dehg_pkg::METADATA_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              entry_valid,
    output logic              entry_stall,
    input  dehg_pkg::entry_t  entry_beat,
    output logic              result_valid,
    input  logic              result_stall,
    output dehg_pkg::result_t result_beat
);

    logic              in_valid_reg;
    dehg_pkg::entry_t  in_data_reg;
    logic              out_valid_reg;
    dehg_pkg::result_t out_data_reg;
    dehg_pkg::result_t core_result;
    logic              advance;

    // stage one moves forward when the result register is empty or being taken
    assign advance     = in_valid_reg && (!out_valid_reg || !result_stall);
    assign entry_stall = in_valid_reg && !advance;

    dehg_core #(
        .METADATA_BYTES(METADATA_BYTES)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .entry   (in_data_reg),
        .result  (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!entry_stall)
            begin
                in_valid_reg <= entry_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (entry_valid && !entry_stall)
        begin
            in_data_reg <= entry_beat;
        end
        if (advance)
        begin
            out_data_reg <= core_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_beat  = out_data_reg;

endmodule
